FILE: rtl/gsup_pkg.sv
`default_nettype none
package gsup_pkg;

  localparam int IouStages = 5;
  localparam logic [16:0] LimitReset = 17'd29491;

  typedef struct packed {
    logic               valid;
    logic               supp;
    logic signed [15:0] left;
    logic signed [15:0] top;
    logic signed [15:0] right;
    logic signed [15:0] bottom;
    logic        [15:0] score;
    logic        [14:0] tag;
  } entry_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_POP,
    ST_PASS,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

FILE: rtl/gsup_if.sv
`default_nettype none
interface gsup_box_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] box_left;
  logic signed [15:0] box_top;
  logic signed [15:0] box_right;
  logic signed [15:0] box_bottom;
  logic        [15:0] box_score;
  logic        [14:0] box_tag;
  logic               final_box;

  modport source(output valid, box_left, box_top, box_right, box_bottom, box_score,
                 box_tag, final_box, input ready);
  modport sink(input valid, box_left, box_top, box_right, box_bottom, box_score,
               box_tag, final_box, output ready);
endinterface

interface gsup_kept_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] kept_left;
  logic signed [15:0] kept_top;
  logic signed [15:0] kept_right;
  logic signed [15:0] kept_bottom;
  logic        [15:0] kept_score;
  logic        [14:0] kept_tag;
  logic               kept_final;
  logic               capacity_overflow;

  modport source(output valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
                 kept_tag, kept_final, capacity_overflow, input ready);
  modport sink(input valid, kept_left, kept_top, kept_right, kept_bottom, kept_score,
               kept_tag, kept_final, capacity_overflow, output ready);
endinterface
`default_nettype wire

FILE: rtl/greedy_box_suppression.sv
`default_nettype none
// channel  | dir | handshake     | payload
// box      | in  | valid / ready | box_left..box_tag, final_box
// kept     | out | valid / ready | kept_left..kept_tag, kept_final, capacity_overflow
// cfg      | in  | cfg_write     | cfg_data (overlap_limit)
//
// Loading: one box per cycle, sorted on entry into the cell chain.
// Per frame: boxes are popped from the head of the chain until it is found empty,
// and each kept box takes a full rotation of the ring through the IoU pipeline,
// plus its output transfer.
// Reset is synchronous; it empties the chain and sets the limit to 29491.
// box.ready is low from the final transfer until the chain has been emptied.
module greedy_box_suppression #(
  parameter int MAX_CANDIDATES  = 64,
  parameter int COORD_FRAC_BITS = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  gsup_box_if.sink         box,
  gsup_kept_if.source      kept,
  input  wire logic        cfg_write,
  input  wire logic [16:0] cfg_data
);

  localparam int CntW  = $clog2(MAX_CANDIDATES + 1);
  localparam int Ring  = MAX_CANDIDATES + gsup_pkg::IouStages;
  localparam int PassW = $clog2(Ring);

  gsup_pkg::state_t   state, state_next;
  logic [CntW-1:0]    count, count_next;
  logic               dropped, dropped_next;
  logic [16:0]        limit;
  gsup_pkg::entry_t   ref_entry;
  logic [PassW-1:0]   pass_cnt, pass_cnt_next;
  logic               survivor, survivor_next;

  gsup_pkg::entry_t   new_entry, tail_entry, iou_out, empty_entry;
  gsup_pkg::entry_t   cells [MAX_CANDIDATES];
  logic               ges [MAX_CANDIDATES];
  gsup_pkg::cell_ctrl_t ctrl;
  logic               in_xfer, full;

  assign in_xfer = box.valid && box.ready;
  assign full    = (count == CntW'(MAX_CANDIDATES));
  assign box.ready = (state == gsup_pkg::ST_LOAD);

  always_comb begin
    new_entry        = '0;
    new_entry.valid  = 1'b1;
    new_entry.left   = box.box_left;
    new_entry.top    = box.box_top;
    new_entry.right  = box.box_right;
    new_entry.bottom = box.box_bottom;
    new_entry.score  = box.box_score;
    new_entry.tag    = box.box_tag;
    empty_entry      = '0;
  end

  assign ctrl.insert = in_xfer && !full;
  assign ctrl.shift  = (state == gsup_pkg::ST_POP) || (state == gsup_pkg::ST_PASS);
  assign tail_entry  = (state == gsup_pkg::ST_PASS) ? iou_out : empty_entry;

  for (genvar i = 0; i < MAX_CANDIDATES; i++) begin : g_cell
    gsup_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i - 1]),
      .left_ge     ((i == 0) ? 1'b1 : ges[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == MAX_CANDIDATES - 1) ? tail_entry
                    : cells[(i == MAX_CANDIDATES - 1) ? i : i + 1]),
      .entry       (cells[i]),
      .ge          (ges[i])
    );
  end

  gsup_iou #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_iou (
    .clk       (clk),
    .rst       (rst),
    .advance   (state == gsup_pkg::ST_PASS),
    .limit     (limit),
    .ref_entry (ref_entry),
    .in_entry  (cells[0]),
    .out_entry (iou_out)
  );

  assign kept.valid             = (state == gsup_pkg::ST_EMIT);
  assign kept.kept_left         = ref_entry.left;
  assign kept.kept_top          = ref_entry.top;
  assign kept.kept_right        = ref_entry.right;
  assign kept.kept_bottom       = ref_entry.bottom;
  assign kept.kept_score        = ref_entry.score;
  assign kept.kept_tag          = ref_entry.tag;
  assign kept.kept_final        = !survivor;
  assign kept.capacity_overflow = dropped;

  always_comb begin
    state_next    = state;
    count_next    = count;
    dropped_next  = dropped;
    pass_cnt_next = pass_cnt;
    survivor_next = survivor;
    unique case (state)
      gsup_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (full) dropped_next = 1'b1;
          else count_next = count + CntW'(1);
          if (box.final_box) state_next = gsup_pkg::ST_POP;
        end
      end
      gsup_pkg::ST_POP: begin
        if (!cells[0].valid) begin
          state_next   = gsup_pkg::ST_LOAD;
          count_next   = '0;
          dropped_next = 1'b0;
        end else if (!cells[0].supp) begin
          state_next    = gsup_pkg::ST_PASS;
          pass_cnt_next = '0;
          survivor_next = 1'b0;
        end
      end
      gsup_pkg::ST_PASS: begin
        if (iou_out.valid && !iou_out.supp) survivor_next = 1'b1;
        pass_cnt_next = pass_cnt + PassW'(1);
        if (pass_cnt == PassW'(Ring - 1)) state_next = gsup_pkg::ST_EMIT;
      end
      gsup_pkg::ST_EMIT: begin
        if (kept.ready) state_next = gsup_pkg::ST_POP;
      end
      default: state_next = gsup_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= gsup_pkg::ST_LOAD;
      count    <= '0;
      dropped  <= 1'b0;
      limit    <= gsup_pkg::LimitReset;
      pass_cnt <= '0;
      survivor <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      dropped  <= dropped_next;
      pass_cnt <= pass_cnt_next;
      survivor <= survivor_next;
      if (cfg_write) limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gsup_pkg::ST_POP) ref_entry <= cells[0];
  end

endmodule
`default_nettype wire

FILE: rtl/gsup_cell.sv
`default_nettype none
module gsup_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gsup_pkg::cell_ctrl_t ctrl,
  input  wire gsup_pkg::entry_t    new_entry,
  input  wire gsup_pkg::entry_t    left_entry,
  input  wire logic                left_ge,
  input  wire gsup_pkg::entry_t    right_entry,
  output gsup_pkg::entry_t         entry,
  output logic                     ge
);

  // ge: this cell stays ahead of the incoming box (ties keep arrival order)
  assign ge = entry.valid && (entry.score >= new_entry.score);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
      entry.supp  <= 1'b0;
    end else if (ctrl.shift) begin
      entry <= right_entry;
    end else if (ctrl.insert && !ge) begin
      entry <= left_ge ? new_entry : left_entry;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/gsup_iou.sv
`default_nettype none
module gsup_iou #(
  parameter int COORD_FRAC_BITS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [16:0]      limit,
  input  wire gsup_pkg::entry_t ref_entry,
  input  wire gsup_pkg::entry_t in_entry,
  output gsup_pkg::entry_t      out_entry
);

  localparam logic signed [17:0] One = 18'sd1 <<< COORD_FRAC_BITS;

  function automatic logic [16:0] side_len(logic signed [15:0] lo, logic signed [15:0] hi);
    logic signed [17:0] s;
    s = 18'(hi) - 18'(lo) + One;
    return s[17] ? 17'd0 : s[16:0];
  endfunction

  function automatic logic signed [15:0] smax(logic signed [15:0] a, logic signed [15:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [15:0] smin(logic signed [15:0] a, logic signed [15:0] b);
    return (a < b) ? a : b;
  endfunction

  gsup_pkg::entry_t e1, e2, e3, e4, e4_hit;
  logic [16:0] iw, ih, cw, ch, rw, rh;
  logic [33:0] inter2, ac2, ar2;
  logic [33:0] inter3;
  logic [34:0] uni3;
  logic [33:0] inter4;
  logic [34:0] plo4;
  logic [33:0] phi4;
  logic        nz4;
  logic [52:0] lhs, rhs;
  logic        hit;

  assign lhs = {3'b000, inter4, 16'd0};
  assign rhs = {1'b0, phi4, 18'd0} + {18'd0, plo4};
  assign hit = e4.valid && nz4 && (lhs > rhs);

  always_comb begin
    e4_hit      = e4;
    e4_hit.supp = e4.supp | hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1.valid <= 1'b0;
      e2.valid <= 1'b0;
      e3.valid <= 1'b0;
      e4.valid <= 1'b0;
      out_entry.valid <= 1'b0;
    end else if (advance) begin
      e1 <= in_entry;
      iw <= side_len(smax(in_entry.left, ref_entry.left), smin(in_entry.right, ref_entry.right));
      ih <= side_len(smax(in_entry.top, ref_entry.top), smin(in_entry.bottom, ref_entry.bottom));
      cw <= side_len(in_entry.left, in_entry.right);
      ch <= side_len(in_entry.top, in_entry.bottom);
      rw <= side_len(ref_entry.left, ref_entry.right);
      rh <= side_len(ref_entry.top, ref_entry.bottom);

      e2     <= e1;
      inter2 <= iw * ih;
      ac2    <= cw * ch;
      ar2    <= rw * rh;

      e3     <= e2;
      inter3 <= inter2;
      uni3   <= {1'b0, ac2} + {1'b0, ar2} - {1'b0, inter2};

      e4     <= e3;
      inter4 <= inter3;
      plo4   <= limit * uni3[17:0];
      phi4   <= limit * uni3[34:18];
      nz4    <= (uni3 != 35'd0);

      out_entry <= e4_hit;
    end
  end

endmodule
`default_nettype wire
